/* rtl/core/ara_pkg.sv */
`timescale 1ns / 1ps

package ara_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int ADDR_BITS   = 32;
  localparam int MASK_W      = 12;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REGIONS);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_REGIONS - 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // value of paddr[2] for each register
  localparam logic REG_POOL  = 1'b0;
  localparam logic REG_ALIGN = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t tail;
  } chain_ctrl_t;

  // bytes from pos up to the next aligned position
  function automatic logic [MASK_W-1:0] pad_for(input logic [MASK_W-1:0] pos,
                                                input logic [MASK_W-1:0] mask);
    logic [MASK_W-1:0] t;
    t = mask + MASK_W'(1) - (pos & mask);
    return t & mask;
  endfunction

endpackage

/* rtl/core/aligned_region_allocator.sv */
`timescale 1ns / 1ps

// Aligned first-fit region allocator. The region table lives in a chain of 16 cells that
// rotates one entry past the controller per cycle during a search, insert or delete pass.
// An allocate that fits past the high-water end goes from S_FIT to an insert pass; one
// that does not runs a search pass, then an insert pass if a gap is found or ST_NOMEM if
// none is; a free runs a delete pass; an allocate into a full table goes straight to
// ST_FULL. One request is worked on at a time; a new request is taken once the previous
// result has moved into the output register, even while that result is still stalled.
// pool_size and align_mask are written through the APB port (byte addresses 0 and 4);
// the user must write them only while no request is in flight, which the block does not
// enforce; align_mask must be a power of two minus one.

module aligned_region_allocator (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          opcode,
  input  logic [ara_pkg::ADDR_BITS-1:0] request_size,
  input  logic [ara_pkg::ADDR_BITS-1:0] region_offset,

  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [ara_pkg::ADDR_BITS-1:0] offset,
  output logic [ara_pkg::ADDR_BITS-1:0] bytes_in_use,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = ara_pkg::ADDR_BITS;
  localparam int MW = ara_pkg::MASK_W;
  localparam int CW = ara_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIT    = 6'b000010,
    S_SEARCH = 6'b000100,
    S_INSERT = 6'b001000,
    S_DELETE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [AW-1:0] pool_size;
  logic [MW-1:0] align_mask;

  logic [CW-1:0] count;
  logic [AW-1:0] hwe;
  logic [AW-1:0] used;

  logic [AW-1:0] size;
  logic [AW-1:0] off;

  logic [CW-1:0] step;
  logic [AW:0]   hw_start;
  logic [AW:0]   prev_end;
  logic [MW-1:0] pad;
  logic [AW:0]   need;
  logic          found;
  logic [AW-1:0] new_start;
  logic          lag;
  logic          inserted;
  logic          matched;
  ara_pkg::entry_t hold;

  logic [1:0]    res_status;
  logic [AW-1:0] res_offset;

  ara_pkg::entry_t      head;
  ara_pkg::chain_ctrl_t chain_ctrl;

  logic [AW:0]   head_end;
  logic [MW-1:0] head_pad;
  logic [AW:0]   head_need;
  logic [AW+1:0] gap_need_end;
  logic          search_fit;
  logic          insert_now;
  logic          match_now;
  logic [AW+1:0] hw_end;
  logic [AW:0]   new_end;
  logic [MW-1:0] hwe_pad;
  logic          cfg_write;

  ara_chain u_chain (
    .clk (clk),
    .ctrl(chain_ctrl),
    .head(head)
  );

  // ---------------- configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = pool_size;
    if (paddr[2] == ara_pkg::REG_ALIGN) begin
      prdata = {{(32 - MW){1'b0}}, align_mask};
    end
  end

  // ---------------- walk datapath
  assign head_end     = {1'b0, head.start} + {1'b0, head.len};
  assign head_pad     = ara_pkg::pad_for(head_end[MW-1:0], align_mask);
  assign head_need    = {1'b0, size} + {{(AW + 1 - MW){1'b0}}, head_pad};
  assign gap_need_end = {1'b0, prev_end} + {1'b0, need};
  // a request needing zero bytes fits any gap, even a negative one
  assign search_fit   = (need == '0) || ({2'b00, head.start} >= gap_need_end);
  assign insert_now   = !inserted && ((step >= count) || (head.start > new_start));
  assign match_now    = !matched && (step < count) && (head.start == off) &&
                        (head.len == size);
  assign hwe_pad      = ara_pkg::pad_for(hwe[MW-1:0], align_mask);
  assign hw_end       = {1'b0, hw_start} + {2'b00, size};
  assign new_end      = {1'b0, new_start} + {1'b0, size};

  always_comb begin
    chain_ctrl.shift = (state == S_SEARCH) || (state == S_INSERT) || (state == S_DELETE);
    chain_ctrl.tail  = head;
    unique case (state)
      S_INSERT: begin
        if (insert_now) begin
          chain_ctrl.tail.start = new_start;
          chain_ctrl.tail.len   = size;
        end else if (lag) begin
          chain_ctrl.tail = hold;
        end
      end
      S_DELETE: begin
        if (lag) begin
          chain_ctrl.tail = hold;
        end
      end
      default: begin
        chain_ctrl.tail = head;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  // ---------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pool_size  <= '0;
      align_mask <= MW'(3);
      count      <= '0;
      hwe        <= '0;
      used       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == ara_pkg::REG_ALIGN) begin
          align_mask <= pwdata[MW-1:0];
        end else begin
          pool_size <= pwdata[AW-1:0];
        end
      end

      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            size     <= request_size;
            off      <= region_offset;
            step     <= '0;
            prev_end <= '0;
            hw_start <= {1'b0, hwe} + {{(AW + 1 - MW){1'b0}}, hwe_pad};
            matched  <= 1'b0;
            inserted <= 1'b0;
            found    <= 1'b0;
            if (opcode == ara_pkg::OP_FREE) begin
              lag   <= 1'b1;
              state <= S_DELETE;
            end else if (count == ara_pkg::CNT_FULL) begin
              res_status <= ara_pkg::ST_FULL;
              res_offset <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_FIT;
            end
          end
        end

        S_FIT: begin
          lag <= 1'b0;
          if (hw_end <= {2'b00, pool_size}) begin
            new_start <= hw_start[AW-1:0];
            state     <= S_INSERT;
          end else begin
            // the first gap starts at zero
            pad   <= ara_pkg::pad_for('0, align_mask);
            need  <= {1'b0, size} +
                     {{(AW + 1 - MW){1'b0}}, ara_pkg::pad_for('0, align_mask)};
            state <= S_SEARCH;
          end
        end

        S_SEARCH: begin
          if (!found && (step < count)) begin
            if (search_fit) begin
              found     <= 1'b1;
              new_start <= prev_end[AW-1:0] + {{(AW - MW){1'b0}}, pad};
            end
            prev_end <= head_end;
            pad      <= head_pad;
            need     <= head_need;
          end
          if (step == ara_pkg::LAST_IDX) begin
            step <= '0;
            if (found || ((step < count) && search_fit)) begin
              state <= S_INSERT;
            end else begin
              res_status <= ara_pkg::ST_NOMEM;
              res_offset <= '0;
              state      <= S_DONE;
            end
          end else begin
            step <= step + 1'b1;
          end
        end

        S_INSERT: begin
          if (insert_now) begin
            inserted <= 1'b1;
            lag      <= 1'b1;
            hold     <= head;
          end else if (lag) begin
            hold <= head;
          end
          step <= step + 1'b1;
          if (step == ara_pkg::LAST_IDX) begin
            count <= count + 1'b1;
            used  <= used + size;
            if (new_end > {1'b0, hwe}) begin
              hwe <= new_end[AW-1:0];
            end
            res_status <= ara_pkg::ST_OK;
            res_offset <= new_start;
            state      <= S_DONE;
          end
        end

        S_DELETE: begin
          // one extra shift drops the beat pushed on the first cycle
          if (match_now) begin
            matched <= 1'b1;
            lag     <= 1'b0;
            if (step == count - 1'b1) begin
              hwe <= (step == '0) ? '0 : prev_end[AW-1:0];
            end
          end else if (lag) begin
            hold <= head;
          end
          prev_end <= head_end;
          step     <= step + 1'b1;
          if (step == ara_pkg::CNT_FULL) begin
            res_offset <= '0;
            if (matched) begin
              count      <= count - 1'b1;
              used       <= used - size;
              res_status <= ara_pkg::ST_OK;
            end else begin
              res_status <= ara_pkg::ST_NOTFOUND;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            status       <= res_status;
            offset       <= res_offset;
            bytes_in_use <= used;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ara_cell.sv */
`timescale 1ns / 1ps

module ara_cell (
  input  logic            clk,
  input  logic            shift,
  input  ara_pkg::entry_t d,
  output ara_pkg::entry_t q
);

  ara_pkg::entry_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

/* rtl/core/ara_chain.sv */
`timescale 1ns / 1ps

module ara_chain (
  input  logic                 clk,
  input  ara_pkg::chain_ctrl_t ctrl,
  output ara_pkg::entry_t      head
);

  ara_pkg::entry_t link [ara_pkg::MAX_REGIONS];

  // each cell takes its right neighbor; the last one takes the tail beat
  for (genvar k = 0; k < ara_pkg::MAX_REGIONS; k++) begin : g_cell
    ara_pkg::entry_t d;
    if (k == ara_pkg::MAX_REGIONS - 1) begin : g_last
      assign d = ctrl.tail;
    end else begin : g_mid
      assign d = link[k + 1];
    end
    ara_cell u_cell (
      .clk  (clk),
      .shift(ctrl.shift),
      .d    (d),
      .q    (link[k])
    );
  end

  assign head = link[0];

endmodule
